// ===== hw/rtl/fss_pkg.sv =====
// Shared types, constants and helper functions of the fair-share scheduler.
// No dependencies; fss_if, fss_div and the scheduler unit refer to it by scoped names.
package fss_pkg;

   localparam int MAX_PROCS = 16;
   localparam int MAX_USERS = 8;

   localparam int SLOT_W  = $clog2(MAX_PROCS);
   localparam int USER_W  = $clog2(MAX_USERS);
   localparam int PROCS_W = $clog2(MAX_PROCS + 1);
   localparam int NUSR_W  = $clog2(MAX_USERS + 1);

   localparam int CMD_W       = 1;
   localparam int OWNER_W     = 3;
   localparam int NEED_W      = 16;
   localparam int SHARE_W     = 32;
   localparam int BLK_W       = 16;
   localparam int TIME_W      = 32;
   localparam int QUANT_W     = 8;
   localparam int BASE_W      = 16;
   localparam int ST_W        = 3;
   localparam int SLOT_OUT_W  = 4;
   localparam int USERS_OUT_W = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   // The divider retires this many quotient bits per cycle.
   localparam int DIV_BITS = 8;
   localparam int DIV_CYC  = SHARE_W / DIV_BITS;
   localparam int DIVC_W   = $clog2(DIV_CYC);

   localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
   localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

   localparam logic [ST_W-1:0] ST_OK    = 3'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 3'd1;
   localparam logic [ST_W-1:0] ST_DONE  = 3'd2;
   localparam logic [ST_W-1:0] ST_TIME  = 3'd3;
   localparam logic [ST_W-1:0] ST_EMPTY = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = 2'd2;

   localparam logic [QUANT_W-1:0] QUANTUM_RST = 8'd1;
   localparam logic [BASE_W-1:0]  BASE_RST    = 16'd0;
   localparam logic [TIME_W-1:0]  LIMIT_RST   = 32'd1000;

   // One process slot as it is kept in the slot memory.
   typedef struct packed {
      logic [USER_W-1:0]  owner;
      logic [NEED_W-1:0]  need;
      logic [NEED_W-1:0]  used;
      logic [SHARE_W-1:0] share;
      logic [SHARE_W-1:0] prio;
      logic [BLK_W-1:0]   blocks;
   } slot_rec_type;

   localparam int REC_W = $bits(slot_rec_type);

   function automatic logic [SHARE_W-1:0] sat_add(input logic [SHARE_W-1:0] a,
                                                  input logic [SHARE_W-1:0] b);
      logic [SHARE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SHARE_W] ? {SHARE_W{1'b1}} : s[SHARE_W-1:0];
   endfunction

   // Folds a user number onto the user table by repeated subtraction.
   function automatic logic [USER_W-1:0] user_of(input logic [OWNER_W-1:0] o);
      int v;
      v = int'(o);
      for (int i = 0; i < (1 << OWNER_W); i++) begin
         if (v >= MAX_USERS) v = v - MAX_USERS;
      end
      return USER_W'(v);
   endfunction

endpackage

// ===== hw/rtl/fss_if.sv =====
// Handshake channels of the fair-share scheduler: request, response, register write.
// Depends on fss_pkg for the field widths.
interface fss_req_if;
   logic                          valid;
   logic                          ready;
   logic [fss_pkg::CMD_W-1:0]     cmd;
   logic [fss_pkg::OWNER_W-1:0]   owner;
   logic [fss_pkg::NEED_W-1:0]    need_time;
   modport source (output valid, cmd, owner, need_time, input ready);
   modport sink   (input valid, cmd, owner, need_time, output ready);
endinterface

interface fss_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [fss_pkg::ST_W-1:0]          status;
   logic [fss_pkg::SLOT_OUT_W-1:0]    slot;
   logic [fss_pkg::OWNER_W-1:0]       run_owner;
   logic [fss_pkg::NEED_W-1:0]        used_time;
   logic                              finished;
   logic [fss_pkg::BLK_W-1:0]         blocked;
   logic [fss_pkg::TIME_W-1:0]        elapsed;
   logic [fss_pkg::USERS_OUT_W-1:0]   users_left;
   modport source (output valid, status, slot, run_owner, used_time, finished, blocked,
                   elapsed, users_left, input ready);
   modport sink   (input valid, status, slot, run_owner, used_time, finished, blocked,
                   elapsed, users_left, output ready);
endinterface

interface fss_csr_if;
   logic                            valid;
   logic                            ready;
   logic [fss_pkg::CSR_IDX_W-1:0]   index;
   logic [fss_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/fair_share_scheduler_unit.sv =====
// Fair-share process scheduler: slot memory, user tables, tick sequencer.
// Depends on fss_pkg, the channel interfaces of fss_if, fss_ram and fss_div.

// The scheduler holds up to MAX_PROCS processes in a slot memory and up to
// MAX_USERS users in small register tables. A load request takes the lowest free
// slot; its response goes through S_FIN into the response register. A tick
// request walks the whole slot memory once to find the live process with the
// lowest priority (one read a cycle), charges it in a read-modify-write of its
// slot, and then, while any user is active, divides every user share and every
// live slot share by the active user count. Each division goes through one shared
// divider. A tick that ends in an error status skips the charge and the divisions.
// One request is worked on at a time; the response waits in an output register, so
// the next request is taken while the previous response is still unclaimed.
// Register writes are always accepted and are meant for idle periods. The slot
// memory needs no clearing after reset: a live bit per slot marks the entries
// that hold a process.
module fair_share_scheduler_unit (
   input logic       clock,
   input logic       reset,
   fss_req_if.sink   req_ch,
   fss_rsp_if.source rsp_ch,
   fss_csr_if.sink   csr_ch
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_DECIDE = 4'd2;
   localparam logic [3:0] S_UPD    = 4'd3;
   localparam logic [3:0] S_BLK    = 4'd4;
   localparam logic [3:0] S_USR_D1 = 4'd5;
   localparam logic [3:0] S_USR_W1 = 4'd6;
   localparam logic [3:0] S_USR_W2 = 4'd7;
   localparam logic [3:0] S_SLT_RD = 4'd8;
   localparam logic [3:0] S_SLT_D1 = 4'd9;
   localparam logic [3:0] S_SLT_W1 = 4'd10;
   localparam logic [3:0] S_SLT_W2 = 4'd11;
   localparam logic [3:0] S_FIN    = 4'd12;

   localparam int SLOT_W  = fss_pkg::SLOT_W;
   localparam int USER_W  = fss_pkg::USER_W;
   localparam int PROCS_W = fss_pkg::PROCS_W;
   localparam int NUSR_W  = fss_pkg::NUSR_W;
   localparam int SHARE_W = fss_pkg::SHARE_W;

   // Configuration registers.
   logic [fss_pkg::QUANT_W-1:0] quantum_ff, quantum_in;
   logic [fss_pkg::BASE_W-1:0]  base_ff, base_in;
   logic [fss_pkg::TIME_W-1:0]  limit_ff, limit_in;

   // Scheduler state outside the slot memory.
   logic [3:0]                  state_ff, state_in;
   logic [fss_pkg::MAX_PROCS-1:0] live_ff, live_in;
   logic [PROCS_W-1:0]          procs_ff [fss_pkg::MAX_USERS];
   logic [PROCS_W-1:0]          procs_in [fss_pkg::MAX_USERS];
   logic [SHARE_W-1:0]          ushare_ff [fss_pkg::MAX_USERS];
   logic [SHARE_W-1:0]          ushare_in [fss_pkg::MAX_USERS];
   logic [SHARE_W-1:0]          uq_ff [fss_pkg::MAX_USERS];
   logic [SHARE_W-1:0]          uq_in [fss_pkg::MAX_USERS];
   logic [fss_pkg::TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic                        loaded_ff, loaded_in;

   // Tick sequencing.
   logic [SLOT_W:0]             scan_ff, scan_in;
   logic                        chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0]           chk_idx_ff, chk_idx_in;
   logic                        found_ff, found_in;
   logic [SHARE_W-1:0]          min_ff, min_in;
   logic [SLOT_W-1:0]           cur_ff, cur_in;
   fss_pkg::slot_rec_type       cur_rec_ff, cur_rec_in;
   fss_pkg::slot_rec_type       wrk_ff, wrk_in;
   logic                        fin_ff, fin_in;
   logic [NUSR_W-1:0]           n_ff, n_in;
   logic [USER_W-1:0]           uidx_ff, uidx_in;
   logic [SLOT_W:0]             sidx_ff, sidx_in;

   // Staged result and the response register.
   logic [fss_pkg::ST_W-1:0]    res_status_ff, res_status_in;
   logic [SLOT_W-1:0]           res_slot_ff, res_slot_in;
   logic [USER_W-1:0]           res_owner_ff, res_owner_in;
   logic [fss_pkg::NEED_W-1:0]  res_used_ff, res_used_in;
   logic                        res_fin_ff, res_fin_in;
   logic [fss_pkg::BLK_W-1:0]   res_blk_ff, res_blk_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [fss_pkg::ST_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [fss_pkg::SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [fss_pkg::OWNER_W-1:0] rsp_owner_ff, rsp_owner_in;
   logic [fss_pkg::NEED_W-1:0]  rsp_used_ff, rsp_used_in;
   logic                        rsp_fin_ff, rsp_fin_in;
   logic [fss_pkg::BLK_W-1:0]   rsp_blk_ff, rsp_blk_in;
   logic [fss_pkg::TIME_W-1:0]  rsp_elapsed_ff, rsp_elapsed_in;
   logic [fss_pkg::USERS_OUT_W-1:0] rsp_users_ff, rsp_users_in;

   // Slot memory and divider connections.
   logic                        ram_we;
   logic [SLOT_W-1:0]           ram_waddr, ram_raddr;
   fss_pkg::slot_rec_type       ram_wdata, ram_rdata;
   logic [fss_pkg::REC_W-1:0]   ram_rdata_raw;
   logic                        div_start, div_busy, div_done;
   logic [SHARE_W-1:0]          div_dividend, div_quot;

   logic [fss_pkg::MAX_USERS-1:0] active;
   logic [NUSR_W-1:0]           n_now;

   fss_ram #(
      .WIDTH (fss_pkg::REC_W),
      .DEPTH (fss_pkg::MAX_PROCS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata_raw)
   );

   assign ram_rdata = fss_pkg::slot_rec_type'(ram_rdata_raw);

   fss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (n_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   // A user is active while it owns at least one live process.
   always_comb begin
      for (int u = 0; u < fss_pkg::MAX_USERS; u++) active[u] = (procs_ff[u] != '0);
      n_now = NUSR_W'($countones(active));
   end

   // Register writes.
   assign csr_ch.ready = 1'b1;
   always_comb begin
      quantum_in = quantum_ff;
      base_in    = base_ff;
      limit_in   = limit_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            fss_pkg::CSR_QUANTUM: quantum_in = csr_ch.data[fss_pkg::QUANT_W-1:0];
            fss_pkg::CSR_BASE:    base_in    = csr_ch.data[fss_pkg::BASE_W-1:0];
            fss_pkg::CSR_LIMIT:   limit_in   = csr_ch.data[fss_pkg::TIME_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      fss_pkg::slot_rec_type rec_v;
      logic [fss_pkg::NEED_W:0]   used_v;
      logic [SHARE_W-1:0]         p_v;
      logic [SHARE_W-1:0]         us_v;
      logic [PROCS_W-1:0]         pc_v;
      logic [USER_W-1:0]          own_v;
      logic [SLOT_W-1:0]          free_v;
      logic                       free_ok;

      state_in      = state_ff;
      live_in       = live_ff;
      procs_in      = procs_ff;
      ushare_in     = ushare_ff;
      uq_in         = uq_ff;
      elapsed_in    = elapsed_ff;
      loaded_in     = loaded_ff;
      scan_in       = scan_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      found_in      = found_ff;
      min_in        = min_ff;
      cur_in        = cur_ff;
      cur_rec_in    = cur_rec_ff;
      wrk_in        = wrk_ff;
      fin_in        = fin_ff;
      n_in          = n_ff;
      uidx_in       = uidx_ff;
      sidx_in       = sidx_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_owner_in  = res_owner_ff;
      res_used_in   = res_used_ff;
      res_fin_in    = res_fin_ff;
      res_blk_in    = res_blk_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_blk_in    = rsp_blk_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      rsp_users_in  = rsp_users_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;
      div_start     = 1'b0;
      div_dividend  = '0;
      rec_v         = cur_rec_ff;
      used_v        = '0;
      p_v           = '0;
      us_v          = '0;
      pc_v          = '0;
      own_v         = '0;

      // Lowest free slot for a load.
      free_v  = '0;
      free_ok = 1'b0;
      for (int s = fss_pkg::MAX_PROCS - 1; s >= 0; s--) begin
         if (!live_ff[s]) begin
            free_v  = SLOT_W'(s);
            free_ok = 1'b1;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               res_used_in = '0;
               res_fin_in  = 1'b0;
               res_blk_in  = '0;
               res_slot_in = '0;
               res_owner_in = '0;
               if (req_ch.cmd == fss_pkg::CMD_LOAD) begin
                  if (!free_ok) begin
                     res_status_in = fss_pkg::ST_FULL;
                  end else begin
                     own_v           = fss_pkg::user_of(req_ch.owner);
                     rec_v.owner     = own_v;
                     rec_v.need      = req_ch.need_time;
                     rec_v.used      = '0;
                     rec_v.share     = '0;
                     rec_v.prio      = SHARE_W'(base_ff);
                     rec_v.blocks    = '0;
                     ram_we          = 1'b1;
                     ram_waddr       = free_v;
                     ram_wdata       = rec_v;
                     live_in[free_v] = 1'b1;
                     procs_in[own_v] = procs_ff[own_v] + 1'b1;
                     loaded_in       = 1'b1;
                     res_status_in   = fss_pkg::ST_OK;
                     res_slot_in     = free_v;
                     res_owner_in    = own_v;
                  end
                  state_in = S_FIN;
               end else begin
                  scan_in    = '0;
                  chk_vld_in = 1'b0;
                  found_in   = 1'b0;
                  state_in   = S_SCAN;
               end
            end
         end

         // One slot read a cycle; the data of the previous read is compared.
         S_SCAN: begin
            ram_raddr  = scan_ff[SLOT_W-1:0];
            chk_vld_in = (scan_ff != (SLOT_W+1)'(fss_pkg::MAX_PROCS));
            chk_idx_in = scan_ff[SLOT_W-1:0];
            if (chk_vld_ff && live_ff[chk_idx_ff] &&
                (!found_ff || ram_rdata.prio < min_ff)) begin
               found_in = 1'b1;
               min_in   = ram_rdata.prio;
               cur_in   = chk_idx_ff;
            end
            if (scan_ff == (SLOT_W+1)'(fss_pkg::MAX_PROCS)) state_in = S_DECIDE;
            else scan_in = scan_ff + 1'b1;
         end

         S_DECIDE: begin
            if (!found_ff) begin
               res_status_in = loaded_ff ? fss_pkg::ST_DONE : fss_pkg::ST_EMPTY;
               state_in      = S_FIN;
            end else if (elapsed_ff >= limit_ff) begin
               res_status_in = fss_pkg::ST_TIME;
               state_in      = S_FIN;
            end else begin
               ram_raddr = cur_ff;
               state_in  = S_UPD;
            end
         end

         // Charge one quantum to the chosen process and its user.
         S_UPD: begin
            rec_v      = ram_rdata;
            own_v      = rec_v.owner;
            used_v     = {1'b0, rec_v.used} + (fss_pkg::NEED_W+1)'(quantum_ff);
            rec_v.used = used_v[fss_pkg::NEED_W-1:0];
            rec_v.share = fss_pkg::sat_add(rec_v.share, SHARE_W'(quantum_ff));
            us_v       = fss_pkg::sat_add(ushare_ff[own_v], SHARE_W'(quantum_ff));
            pc_v       = procs_ff[own_v];
            elapsed_in = fss_pkg::sat_add(elapsed_ff, SHARE_W'(quantum_ff));
            fin_in     = 1'b0;
            if (used_v >= {1'b0, rec_v.need}) begin
               // The process is done: clamp, retire, and charge the extra quantum.
               rec_v.used = rec_v.need;
               fin_in     = 1'b1;
               if (pc_v != '0) pc_v = pc_v - 1'b1;
               elapsed_in = fss_pkg::sat_add(
                  fss_pkg::sat_add(elapsed_ff, SHARE_W'(quantum_ff)),
                  SHARE_W'(quantum_ff));
               if (pc_v == '0) us_v = '0;
               live_in[cur_ff] = 1'b0;
            end
            procs_in[own_v]  = pc_v;
            ushare_in[own_v] = us_v;
            cur_rec_in       = rec_v;
            state_in         = S_BLK;
         end

         // The blocked count follows the user count left after a retirement.
         S_BLK: begin
            rec_v = cur_rec_ff;
            if (n_now > NUSR_W'(1) && rec_v.blocks != {fss_pkg::BLK_W{1'b1}}) begin
               rec_v.blocks = rec_v.blocks + 1'b1;
            end
            ram_we        = 1'b1;
            ram_waddr     = cur_ff;
            ram_wdata     = rec_v;
            cur_rec_in    = rec_v;
            n_in          = n_now;
            res_status_in = fss_pkg::ST_OK;
            res_slot_in   = cur_ff;
            res_owner_in  = rec_v.owner;
            res_used_in   = rec_v.used;
            res_fin_in    = fin_ff;
            res_blk_in    = rec_v.blocks;
            uidx_in       = '0;
            sidx_in       = '0;
            state_in      = (n_now == '0) ? S_FIN : S_USR_D1;
         end

         S_USR_D1: begin
            div_start    = 1'b1;
            div_dividend = ushare_ff[uidx_ff];
            state_in     = S_USR_W1;
         end

         S_USR_W1: begin
            if (div_done) begin
               ushare_in[uidx_ff] = div_quot;
               div_start          = 1'b1;
               div_dividend       = div_quot;
               state_in           = S_USR_W2;
            end
         end

         // Keep share/n/n per user for the priority of its slots.
         S_USR_W2: begin
            if (div_done) begin
               uq_in[uidx_ff] = div_quot;
               if (uidx_ff == USER_W'(fss_pkg::MAX_USERS - 1)) begin
                  state_in = S_SLT_RD;
               end else begin
                  uidx_in  = uidx_ff + 1'b1;
                  state_in = S_USR_D1;
               end
            end
         end

         S_SLT_RD: begin
            if (sidx_ff == (SLOT_W+1)'(fss_pkg::MAX_PROCS)) begin
               state_in = S_FIN;
            end else if (live_ff[sidx_ff[SLOT_W-1:0]]) begin
               ram_raddr = sidx_ff[SLOT_W-1:0];
               state_in  = S_SLT_D1;
            end else begin
               sidx_in = sidx_ff + 1'b1;
            end
         end

         S_SLT_D1: begin
            wrk_in       = ram_rdata;
            div_start    = 1'b1;
            div_dividend = ram_rdata.share;
            state_in     = S_SLT_W1;
         end

         S_SLT_W1: begin
            if (div_done) begin
               wrk_in.share = div_quot;
               div_start    = 1'b1;
               div_dividend = div_quot;
               state_in     = S_SLT_W2;
            end
         end

         S_SLT_W2: begin
            if (div_done) begin
               rec_v      = wrk_ff;
               p_v        = fss_pkg::sat_add(div_quot, uq_ff[wrk_ff.owner]);
               rec_v.prio = fss_pkg::sat_add(p_v, SHARE_W'(base_ff));
               ram_we     = 1'b1;
               ram_waddr  = sidx_ff[SLOT_W-1:0];
               ram_wdata  = rec_v;
               sidx_in    = sidx_ff + 1'b1;
               state_in   = S_SLT_RD;
            end
         end

         // Hand the result to the response register once it is free.
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_slot_in    = fss_pkg::SLOT_OUT_W'(res_slot_ff);
               rsp_owner_in   = fss_pkg::OWNER_W'(res_owner_ff);
               rsp_used_in    = res_used_ff;
               rsp_fin_in     = res_fin_ff;
               rsp_blk_in     = res_blk_ff;
               rsp_elapsed_in = elapsed_ff;
               rsp_users_in   = fss_pkg::USERS_OUT_W'(n_now);
               state_in       = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         quantum_ff   <= fss_pkg::QUANTUM_RST;
         base_ff      <= fss_pkg::BASE_RST;
         limit_ff     <= fss_pkg::LIMIT_RST;
         live_ff      <= '0;
         elapsed_ff   <= '0;
         loaded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         for (int u = 0; u < fss_pkg::MAX_USERS; u++) begin
            procs_ff[u]  <= '0;
            ushare_ff[u] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         quantum_ff   <= quantum_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         live_ff      <= live_in;
         elapsed_ff   <= elapsed_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
         procs_ff     <= procs_in;
         ushare_ff    <= ushare_in;
      end
      uq_ff          <= uq_in;
      scan_ff        <= scan_in;
      chk_idx_ff     <= chk_idx_in;
      found_ff       <= found_in;
      min_ff         <= min_in;
      cur_ff         <= cur_in;
      cur_rec_ff     <= cur_rec_in;
      wrk_ff         <= wrk_in;
      fin_ff         <= fin_in;
      n_ff           <= n_in;
      uidx_ff        <= uidx_in;
      sidx_ff        <= sidx_in;
      res_status_ff  <= res_status_in;
      res_slot_ff    <= res_slot_in;
      res_owner_ff   <= res_owner_in;
      res_used_ff    <= res_used_in;
      res_fin_ff     <= res_fin_in;
      res_blk_ff     <= res_blk_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_owner_ff   <= rsp_owner_in;
      rsp_used_ff    <= rsp_used_in;
      rsp_fin_ff     <= rsp_fin_in;
      rsp_blk_ff     <= rsp_blk_in;
      rsp_elapsed_ff <= rsp_elapsed_in;
      rsp_users_ff   <= rsp_users_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.slot       = rsp_slot_ff;
   assign rsp_ch.run_owner  = rsp_owner_ff;
   assign rsp_ch.used_time  = rsp_used_ff;
   assign rsp_ch.finished   = rsp_fin_ff;
   assign rsp_ch.blocked    = rsp_blk_ff;
   assign rsp_ch.elapsed    = rsp_elapsed_ff;
   assign rsp_ch.users_left = rsp_users_ff;

`ifndef SYNTH
   // A load into a free slot adds exactly one live process.
   a_load_adds_one: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.cmd == fss_pkg::CMD_LOAD && !(&live_ff))
      |=> $countones(live_ff) == $past($countones(live_ff)) + 1)
      else $error("load did not occupy one slot");
   // There are never more active users than live processes.
   a_users_have_slots: assert property (@(posedge clock) disable iff (reset)
      $countones(active) <= $countones(live_ff))
      else $error("active user without a live process");
   // A retirement is only reported on a successful tick.
   a_finish_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.finished) |-> rsp_ch.status == fss_pkg::ST_OK)
      else $error("finished flag on an error response");
   // The divider is only started while it is free.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");
`endif
endmodule

// ===== hw/rtl/fss_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module fss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/fss_div.sv =====
// Iterative divider of a share count by the active user count, DIV_BITS bits a cycle.
// Depends on fss_pkg.
module fss_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fss_pkg::SHARE_W-1:0]  dividend,
   input  logic [fss_pkg::NUSR_W-1:0]   divisor,
   output logic                         busy,
   output logic                         done,
   output logic [fss_pkg::SHARE_W-1:0]  quotient
);
   logic [fss_pkg::SHARE_W-1:0] q_ff, q_in;
   logic [fss_pkg::NUSR_W-1:0]  rem_ff, rem_in;
   logic [fss_pkg::NUSR_W-1:0]  dvs_ff, dvs_in;
   logic [fss_pkg::DIVC_W-1:0]  cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   always_comb begin
      logic [fss_pkg::NUSR_W:0]    t;
      logic [fss_pkg::SHARE_W-1:0] q;
      logic [fss_pkg::NUSR_W-1:0]  r;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      t       = '0;
      q       = q_ff;
      r       = rem_ff;
      if (busy_ff) begin
         // Restoring division; the remainder stays below the small divisor.
         for (int i = 0; i < fss_pkg::DIV_BITS; i++) begin
            t = {r, q[fss_pkg::SHARE_W-1]};
            q = {q[fss_pkg::SHARE_W-2:0], 1'b0};
            if (t >= {1'b0, dvs_ff}) begin
               t    = t - {1'b0, dvs_ff};
               q[0] = 1'b1;
            end
            r = t[fss_pkg::NUSR_W-1:0];
         end
         q_in   = q;
         rem_in = r;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == fss_pkg::DIVC_W'(fss_pkg::DIV_CYC - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = q_ff;

`ifndef SYNTH
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(busy))
      else $error("divider finished without running");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("divider did not take a start");
   a_no_done_pair: assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("divider finished twice in a row");
`endif
endmodule
